// ----- design/mm2_pkg.sv -----
// Shared constants and queue entry type for the MurmurHash2 key hasher.
package mm2_pkg;

  localparam logic [31:0] MIX_M      = 32'h5bd1e995;
  localparam int          MIX_R      = 24;
  localparam int          FIN_A      = 13;
  localparam int          FIN_B      = 15;
  localparam logic [31:0] SEED_RESET = 32'd5381;

  // Configuration address: register index sits in the top bit
  localparam int          CFG_ADDR_W = 3;
  localparam logic        REG_SEED   = 1'b0;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_WORD = 2'd1,
    KIND_TAIL = 2'd2
  } kind_t;

  typedef struct packed {
    logic [31:0] word;
    kind_t       kind;
    logic        first;
    logic        last;
    logic [15:0] klen;
  } entry_t;

endpackage

// ----- design/mm2_ifs.sv -----
// Stream interfaces for key words in and hash results out.
interface mm2_key_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic [15:0] key_length;
  logic        first;
  logic        last;

  modport source(output valid, data_word, valid_bytes, key_length, first, last, input ready);
  modport sink(input valid, data_word, valid_bytes, key_length, first, last, output ready);
endinterface

interface mm2_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source(output valid, hash_value, input ready);
  modport sink(input valid, hash_value, output ready);
endinterface

// ----- design/murmur2_key_hasher.sv -----
// Top level of the streaming 32-bit MurmurHash2 key hasher.
//
//   port    dir   handshake      payload
//   key     in    valid/ready    data_word, valid_bytes, key_length, first, last
//   hash    out   valid/ready    hash_value
//   apb     in    psel/penable   paddr, pwdata -> seed at index 0
//
// The back end runs one request at a time on a single 32x32 multiplier by m:
// a full word runs load, two key multiplies and a hash multiply; a tail, load
// and one fold; an empty word, load alone; a last request adds finalize, emit.
// The front end accepts a request every cycle while the queue has room.
// Reset clears the queue, the running hash and the output; seed returns to 5381.
// A stalled hash output holds the back end in its emit step only.
module murmur2_key_hasher import mm2_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  mm2_key_if.sink               key,
  mm2_hash_if.source            hash,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  logic [31:0]      seed;
  logic             q_push;
  entry_t           q_push_data;
  logic             q_pop;
  entry_t           q_head;
  logic             q_empty;
  logic             q_full;
  logic [LVL_W-1:0] q_level;
  logic             sel_seed;

  assign sel_seed = (paddr[CFG_ADDR_W-1] == REG_SEED);
  assign pready   = 1'b1;
  assign prdata   = sel_seed ? seed : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (psel && penable && pwrite && sel_seed) begin
      seed <= pwdata;
    end
  end

  mm2_front u_front (
    .key       (key),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  mm2_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full),
    .level     (q_level)
  );

  mm2_back u_back (
    .clk   (clk),
    .rst   (rst),
    .seed  (seed),
    .head  (q_head),
    .empty (q_empty),
    .pop   (q_pop),
    .hash  (hash)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

  a_level_up: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> (q_level == $past(q_level) + LVL_W'(1)))
    else $error("queue level did not grow on push");

  a_level_down: assert property (@(posedge clk) disable iff (rst)
    (q_pop && !q_push) |=> (q_level == $past(q_level) - LVL_W'(1)))
    else $error("queue level did not shrink on pop");

endmodule

// ----- design/mm2_front.sv -----
// Front end: accepts key words, masks tail bytes and classifies each request.
module mm2_front import mm2_pkg::*; (
  mm2_key_if.sink  key,
  input  logic     q_full,
  output logic     push,
  output entry_t   push_data
);

  always_comb begin
    push_data.first = key.first;
    push_data.last  = key.last;
    push_data.klen  = key.key_length;
    case (key.valid_bytes)
      3'd0: begin
        push_data.kind = KIND_NONE;
        push_data.word = '0;
      end
      3'd1: begin
        push_data.kind = KIND_TAIL;
        push_data.word = {24'd0, key.data_word[7:0]};
      end
      3'd2: begin
        push_data.kind = KIND_TAIL;
        push_data.word = {16'd0, key.data_word[15:0]};
      end
      3'd3: begin
        push_data.kind = KIND_TAIL;
        push_data.word = {8'd0, key.data_word[23:0]};
      end
      // four or more: full word
      default: begin
        push_data.kind = KIND_WORD;
        push_data.word = key.data_word;
      end
    endcase
  end

  assign key.ready = !q_full;
  assign push      = key.valid && !q_full;

endmodule

// ----- design/mm2_queue.sv -----
// Small FIFO of classified requests between front end and back end.
module mm2_queue import mm2_pkg::*; #(
  parameter int  DEPTH = 4,
  localparam int LVL_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  entry_t           push_data,
  input  logic             pop,
  output entry_t           head,
  output logic             empty,
  output logic             full,
  output logic [LVL_W-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= advance(rd_ptr);
      end
      if (push && !pop) begin
        level <= level + LVL_W'(1);
      end else if (pop && !push) begin
        level <= level - LVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign head  = mem[rd_ptr];
  assign empty = (level == '0);
  assign full  = (level == LVL_W'(DEPTH));

endmodule

// ----- design/mm2_back.sv -----
// Back end: sequences word mix, tail fold and finalization on one shared multiplier.
module mm2_back import mm2_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] seed,
  input  entry_t      head,
  input  logic        empty,
  output logic        pop,
  mm2_hash_if.source  hash
);

  typedef enum logic [6:0] {
    ST_LOAD = 7'b0000001,
    ST_MK1  = 7'b0000010,
    ST_MK2  = 7'b0000100,
    ST_MH   = 7'b0001000,
    ST_TAIL = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t      state, state_next;
  logic [31:0] running_hash, running_hash_next;
  logic [31:0] k, k_next;
  logic [31:0] fin, fin_next;
  logic        last_q, last_q_next;
  logic        out_valid, out_valid_next;
  logic [31:0] out_hash, out_hash_next;
  logic [31:0] mul_in;
  logic [31:0] product;
  logic [31:0] h_start;

  // every multiply in the algorithm is by the same constant
  assign product = mul_in * MIX_M;
  assign h_start = head.first ? (seed ^ {16'd0, head.klen}) : running_hash;

  always_comb begin
    state_next        = state;
    running_hash_next = running_hash;
    k_next            = k;
    fin_next          = fin;
    last_q_next       = last_q;
    out_hash_next     = out_hash;
    out_valid_next    = out_valid && !hash.ready;
    mul_in            = '0;
    pop               = 1'b0;
    case (state)
      ST_LOAD: begin
        if (!empty) begin
          pop               = 1'b1;
          running_hash_next = h_start;
          k_next            = head.word;
          last_q_next       = head.last;
          case (head.kind)
            KIND_WORD: state_next = ST_MK1;
            KIND_TAIL: state_next = ST_TAIL;
            default:   state_next = head.last ? ST_FIN : ST_LOAD;
          endcase
        end
      end
      ST_MK1: begin
        mul_in     = k;
        k_next     = product;
        state_next = ST_MK2;
      end
      ST_MK2: begin
        mul_in     = k ^ (k >> MIX_R);
        k_next     = product;
        state_next = ST_MH;
      end
      ST_MH: begin
        mul_in            = running_hash;
        running_hash_next = product ^ k;
        state_next        = last_q ? ST_FIN : ST_LOAD;
      end
      ST_TAIL: begin
        mul_in            = running_hash ^ k;
        running_hash_next = product;
        state_next        = last_q ? ST_FIN : ST_LOAD;
      end
      ST_FIN: begin
        // running_hash keeps the pre-finalization value
        mul_in     = running_hash ^ (running_hash >> FIN_A);
        fin_next   = product;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid || hash.ready) begin
          out_hash_next  = fin ^ (fin >> FIN_B);
          out_valid_next = 1'b1;
          state_next     = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      running_hash <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      running_hash <= running_hash_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k        <= k_next;
    fin      <= fin_next;
    last_q   <= last_q_next;
    out_hash <= out_hash_next;
  end

  assign hash.valid      = out_valid;
  assign hash.hash_value = out_hash;

endmodule

// ----- tb/tb.sv -----
// Testbench for the streaming MurmurHash2 key hasher: random keys, bursty traffic, scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mm2_pkg::*;

  localparam int DRAIN_CYCLES   = 48;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 272;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic [15:0] klen;
    logic        first;
    logic        last;
  } key_req_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  mm2_key_if  key_ch();
  mm2_hash_if hash_ch();

  murmur2_key_hasher u_top (
    .clk     (clk),
    .rst     (rst),
    .key     (key_ch),
    .hash    (hash_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  key_req_t    key_req_q[$];
  logic [31:0] digest_q[$];
  logic [31:0] seed_copy = SEED_RESET;
  logic [31:0] chain_hash;
  int          err_count = 0;
  int          cyc_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_left = 0;

  // ---------------------------------------------------------------- predictor
  function automatic logic [31:0] mix_full_word(logic [31:0] h, logic [31:0] k);
    k = k * MIX_M;
    k = k ^ (k >> MIX_R);
    k = k * MIX_M;
    h = h * MIX_M;
    return h ^ k;
  endfunction

  function automatic logic [31:0] murmur_finish(logic [31:0] h);
    h = h ^ (h >> FIN_A);
    h = h * MIX_M;
    return h ^ (h >> FIN_B);
  endfunction

  function automatic void advance_hash(key_req_t r);
    logic [31:0] h;
    logic [2:0]  n;
    n = (r.nbytes > 3'd4) ? 3'd4 : r.nbytes;
    h = r.first ? (seed_copy ^ {16'd0, r.klen}) : chain_hash;
    if (n == 3'd4) begin
      h = mix_full_word(h, r.word);
    end else if (n != 3'd0) begin
      // tail cascade: high byte first, then one multiply
      if (n >= 3'd3) h = h ^ {8'd0, r.word[23:16], 16'd0};
      if (n >= 3'd2) h = h ^ {16'd0, r.word[15:8], 8'd0};
      h = h ^ {24'd0, r.word[7:0]};
      h = h * MIX_M;
    end
    chain_hash = h;
    if (r.last) digest_q.push_back(murmur_finish(h));
  endfunction

  // ---------------------------------------------------------------- key driver
  always @(posedge clk) begin : key_driver
    key_req_t r;
    if (rst) begin
      key_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!key_ch.valid || key_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        key_ch.valid <= 1'b0;
      end else if (key_req_q.size() > 0) begin
        r = key_req_q.pop_front();
        key_ch.valid       <= 1'b1;
        key_ch.data_word   <= r.word;
        key_ch.valid_bytes <= r.nbytes;
        key_ch.key_length  <= r.klen;
        key_ch.first       <= r.first;
        key_ch.last        <= r.last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          // hold back-to-back for long stretches now and then
          if (cyc_count[10] || $urandom_range(0, 3) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        key_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- hash receiver
  always @(posedge clk) begin
    if (rst) begin
      hash_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      hash_ch.ready <= 1'b0;
    end else begin
      case (cyc_count[9:8])
        2'd0: hash_ch.ready <= 1'b1;
        2'd1: hash_ch.ready <= ($urandom_range(0, 3) != 0);
        2'd2: begin
          if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 20);
            hash_ch.ready <= 1'b0;
          end else begin
            hash_ch.ready <= 1'b1;
          end
        end
        default: hash_ch.ready <= cyc_count[0];
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : hash_monitor
    key_req_t    seen;
    logic [31:0] want;
    if (rst) begin
      chain_hash = '0;
    end else begin
      if (key_ch.valid && key_ch.ready) begin
        seen.word   = key_ch.data_word;
        seen.nbytes = key_ch.valid_bytes;
        seen.klen   = key_ch.key_length;
        seen.first  = key_ch.first;
        seen.last   = key_ch.last;
        advance_hash(seen);
      end
      if (hash_ch.valid && hash_ch.ready) begin
        if (digest_q.size() == 0) begin
          $error("hash_value: none expected, actual %h", hash_ch.hash_value);
          err_count++;
        end else begin
          want = digest_q.pop_front();
          if (hash_ch.hash_value !== want) begin
            $error("hash_value mismatch: expected %h, actual %h", want, hash_ch.hash_value);
            err_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    cyc_count++;
    if (rst || (key_ch.valid && key_ch.ready) || (hash_ch.valid && hash_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic push_req(logic [31:0] word, logic [2:0] nbytes, logic [15:0] klen,
                          logic first, logic last);
    key_req_t r;
    r.word   = word;
    r.nbytes = nbytes;
    r.klen   = klen;
    r.first  = first;
    r.last   = last;
    key_req_q.push_back(r);
  endtask

  // one key; a flawed key drops first or last, or carries odd byte counts
  task automatic gen_key(input bit flawed, output int n_words);
    int len;
    int flaw;
    int odd_at;
    int pick;
    logic [2:0]  nb;
    logic [15:0] kl;
    pick = $urandom_range(0, 99);
    if (pick < 70) len = $urandom_range(0, 16);
    else if (pick < 95) len = $urandom_range(17, 64);
    else len = $urandom_range(65, 200);
    n_words = (len == 0) ? 1 : (len + 3) / 4;
    flaw = flawed ? $urandom_range(1, 4) : 0;
    odd_at = $urandom_range(0, n_words - 1);
    for (int i = 0; i < n_words; i++) begin
      nb = (i == n_words - 1) ? 3'(len - 4 * i) : 3'd4;
      if (flaw == 2 && i == odd_at && i != n_words - 1) nb = 3'($urandom_range(0, 3));
      if (flaw == 4 && nb == 3'd4 && $urandom_range(0, 1)) nb = 3'($urandom_range(5, 7));
      if (i == 0 && $urandom_range(0, 9) != 0) kl = 16'(len);
      else kl = 16'($urandom_range(0, 65535));
      push_req($urandom, nb, kl, (i == 0) && (flaw != 1),
               (i == n_words - 1) && (flaw != 3));
    end
  endtask

  task automatic gen_phase(int n_items);
    int made;
    int n;
    made = 0;
    while (made < n_items) begin
      n = $urandom_range(0, 99);
      if (n < 8) begin
        push_req($urandom, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        made++;
      end else begin
        gen_key(n < 20, n);
        made += n;
      end
    end
  endtask

  // hold until the block has drained every request and result
  task automatic wait_idle();
    do @(negedge clk);
    while (key_req_q.size() != 0 || key_ch.valid || digest_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SEED, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seed_copy = value;
  endtask

  initial begin
    logic [31:0] seeds[6];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    key_ch.valid = 1'b0;
    key_ch.data_word = '0;
    key_ch.valid_bytes = '0;
    key_ch.key_length = '0;
    key_ch.first = 1'b0;
    key_ch.last = 1'b0;
    hash_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // no first after reset: continue from the cleared hash, then from the kept one
    push_req(32'hDEADBEEF, 3'd4, 16'h1234, 1'b0, 1'b1);
    push_req($urandom, 3'd2, 16'h0000, 1'b0, 1'b1);
    // empty keys
    push_req(32'h0000_0000, 3'd0, 16'h0000, 1'b1, 1'b1);
    push_req(32'hFFFF_FFFF, 3'd0, 16'hFFFF, 1'b1, 1'b1);
    // one-word keys, the short ones with stray bytes above the count
    push_req(32'hFFFF_FFFF, 3'd1, 16'd1, 1'b1, 1'b1);
    push_req(32'h80FF_7F01, 3'd2, 16'd2, 1'b1, 1'b1);
    push_req(32'hFFFF_FFFF, 3'd3, 16'd3, 1'b1, 1'b1);
    push_req(32'h0000_0000, 3'd4, 16'd4, 1'b1, 1'b1);
    push_req(32'hFFFF_FFFF, 3'd4, 16'd4, 1'b1, 1'b1);
    // oversized counts act as full words
    push_req(32'h1234_5678, 3'd5, 16'd12, 1'b1, 1'b0);
    push_req(32'h9ABC_DEF0, 3'd6, 16'd12, 1'b0, 1'b0);
    push_req(32'h0F0F_F0F0, 3'd7, 16'd12, 1'b0, 1'b1);
    // short word mid-stream folds in as a tail
    push_req(32'hA5A5_5A5A, 3'd1, 16'd9, 1'b1, 1'b0);
    push_req(32'h7E7E_8181, 3'd3, 16'd9, 1'b0, 1'b0);
    push_req(32'hCAFE_F00D, 3'd4, 16'd9, 1'b0, 1'b1);
    // empty word at the end leaves the hash alone
    push_req(32'h1111_1111, 3'd4, 16'd4, 1'b1, 1'b0);
    push_req(32'hFFFF_FFFF, 3'd0, 16'd4, 1'b0, 1'b1);
    // length that does not match the words sent
    push_req(32'h0102_0304, 3'd4, 16'hA5A5, 1'b1, 1'b0);
    push_req(32'h8000_0000, 3'd4, 16'h5A5A, 1'b0, 1'b1);
    // a word with neither mark, then a closing empty word
    push_req(32'h7FFF_FFFF, 3'd4, 16'h8000, 1'b0, 1'b0);
    push_req(32'h0000_0001, 3'd0, 16'h7FFF, 1'b0, 1'b1);
    wait_idle();

    seeds[0] = 32'h0000_0000;
    seeds[1] = 32'hFFFF_FFFF;
    seeds[2] = $urandom;
    seeds[3] = $urandom;
    seeds[4] = $urandom;
    seeds[5] = SEED_RESET;
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      gen_phase(PHASE_ITEMS);
      wait_idle();
    end

    if (err_count == 0 && digest_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
